/* sv/mmac_pkg.sv */
// Shared constants for the mod-q matrix multiply-accumulate block.
// Operation codes, register indexes, reset values and default sizes.
// No dependencies.
`default_nettype none

package mmac_pkg;

    localparam int MAX_COLUMNS_DEF = 8;
    localparam int MAX_INNER_DEF   = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam int VALUE_W = 16;

    localparam logic [1:0] OP_RIGHT  = 2'd0;
    localparam logic [1:0] OP_ADDEND = 2'd1;
    localparam logic [1:0] OP_LEFT   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] REG_INNER_LENGTH   = 2'd0;
    localparam logic [1:0] REG_COLUMNS_IN_USE = 2'd1;
    localparam logic [1:0] REG_LOG_MODULUS    = 2'd2;

    localparam logic [10:0] INNER_LENGTH_RST   = 11'd1024;
    localparam logic [3:0]  COLUMNS_IN_USE_RST = 4'd8;
    localparam logic [4:0]  LOG_MODULUS_RST    = 5'd12;

endpackage

`default_nettype wire

/* sv/mmac_fifo.sv */
// Small request queue between the front and back sections.
// Register-array FIFO, show-ahead read. Uses mmac_pkg for the default depth.
`default_nettype none

module mmac_fifo
    import mmac_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [NW-1:0]    r_count;

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == NW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* sv/mmac_front.sv */
// Front section: input handshake and request classification.
// Drops requests with no effect, tags the row-closing element. Uses mmac_pkg.
`default_nettype none

module mmac_front
    import mmac_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_INNER   = MAX_INNER_DEF,
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int IW    = $clog2(MAX_INNER),
    localparam int LW    = $clog2(MAX_INNER + 1),
    localparam int REQ_W = 2 + CW + IW + VALUE_W + 1
) (
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_operation,
    input  wire logic [2:0]         i_column,
    input  wire logic [9:0]         i_inner_index,
    input  wire logic [15:0]        i_value,
    input  wire logic [LW-1:0]      i_len,
    input  wire logic               i_full,
    output logic                    o_push,
    output logic      [REQ_W-1:0]   o_req
);

    logic col_ok;
    logic idx_ok;
    logic in_row;
    logic keep;
    logic last;

    assign col_ok = (32'(i_column) < MAX_COLUMNS);
    assign idx_ok = (32'(i_inner_index) < MAX_INNER);
    assign in_row = (32'(i_inner_index) < 32'(i_len));

    always_comb begin
        unique case (i_operation)
            OP_RIGHT:  keep = col_ok && idx_ok;
            OP_ADDEND: keep = col_ok;
            OP_LEFT:   keep = in_row;
            default:   keep = 1'b0;
        endcase
    end

    assign last = (i_operation == OP_LEFT) && (32'(i_inner_index) + 1 == 32'(i_len));

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full && keep;
    assign o_req      = {i_operation, CW'(i_column), IW'(i_inner_index), i_value, last};

endmodule

`default_nettype wire

/* sv/mmac_back.sv */
// Back section: right-matrix memory, addends, column accumulators, result output.
// Executes queued requests one at a time. Uses mmac_pkg.
`default_nettype none

module mmac_back
    import mmac_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_INNER   = MAX_INNER_DEF,
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int IW    = $clog2(MAX_INNER),
    localparam int CNW   = $clog2(MAX_COLUMNS + 1),
    localparam int REQ_W = 2 + CW + IW + VALUE_W + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [REQ_W-1:0]   i_req,
    input  wire logic               i_req_valid,
    output logic                    o_pop,
    input  wire logic [CNW-1:0]     i_cols,
    input  wire logic [15:0]        i_qmask,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [15:0]        o_result_value,
    output logic      [2:0]         o_result_column,
    output logic                    o_row_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          req_kind;
    logic [CW-1:0]       req_col;
    logic [IW-1:0]       req_idx;
    logic [15:0]         req_value;
    logic                req_last;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [MAX_COLUMNS*16-1:0] r_mem [MAX_INNER];
    logic [MAX_COLUMNS*16-1:0] r_rdata;
    logic [15:0]         r_val;
    logic                r_last;
    logic [15:0]         r_prod [MAX_COLUMNS];
    logic [15:0]         r_acc  [MAX_COLUMNS];
    logic [15:0]         r_add  [MAX_COLUMNS];
    logic [CW-1:0]       r_cnt;
    logic                r_out_valid;
    logic [15:0]         r_out_value;
    logic [2:0]          r_out_column;
    logic                r_out_last;

    logic                emit_load;
    logic                emit_done;
    logic [15:0]         emit_sum;

    assign {req_kind, req_col, req_idx, req_value, req_last} = i_req;

    assign o_pop     = (r_state == ST_IDLE) && i_req_valid;
    assign emit_load = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign emit_done = (CNW'(r_cnt) == i_cols - CNW'(1));
    assign emit_sum  = r_acc[r_cnt] + r_add[r_cnt];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && req_kind == OP_LEFT) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_ACC;
            ST_ACC:  n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (emit_load && emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && req_kind == OP_RIGHT) begin
            r_mem[req_idx][{req_col, 4'b0000} +: 16] <= req_value;
        end
        if (o_pop && req_kind == OP_LEFT) begin
            r_rdata <= r_mem[req_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && req_kind == OP_LEFT) begin
            r_val <= req_value;
        end
        if (r_state == ST_READ) begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                r_prod[c] <= r_val * r_rdata[c*16 +: 16];
            end
        end
        if (emit_load) begin
            r_out_value  <= emit_sum & i_qmask;
            r_out_column <= 3'(r_cnt);
            r_out_last   <= emit_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                r_acc[c] <= '0;
                r_add[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop && req_kind == OP_LEFT) begin
                r_last <= req_last;
            end
            if (r_state == ST_ACC) begin
                for (int c = 0; c < MAX_COLUMNS; c++) begin
                    if (CNW'(c) < i_cols) begin
                        r_acc[c] <= r_acc[c] + r_prod[c];
                    end
                end
            end
            if (o_pop && req_kind == OP_ADDEND) begin
                r_add[req_col] <= req_value;
            end
            if (emit_load) begin
                r_cnt <= emit_done ? '0 : r_cnt + CW'(1);
                if (emit_done) begin
                    for (int c = 0; c < MAX_COLUMNS; c++) begin
                        r_acc[c] <= '0;
                        r_add[c] <= '0;
                    end
                end
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_result_column = r_out_column;
    assign o_row_last      = r_out_last;

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result raised outside emit phase");

    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> $past(r_state == ST_READ))
        else $error("accumulate without memory read");

    a_row_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && emit_done) |=> (r_acc[0] == '0 && r_add[0] == '0 && r_cnt == '0))
        else $error("row end did not clear column state");

endmodule

`default_nettype wire

/* sv/modq_matrix_multiply_accumulate.sv */
// Matrix product mod 2^log_modulus with per-column addends, streaming rows.
// Instances mmac_front, mmac_fifo, mmac_back; uses mmac_pkg.
//
// Input channel (i_in_valid / o_in_ready): one request per accept. Operation
// 0 writes a right-matrix element (column, inner index), 1 writes a column
// addend, 2 streams a left-matrix element. Requests with no effect are
// dropped at the front. Accepted requests queue (4 deep) ahead of the back
// section, which runs them one at a time.
// Loads complete in the back section when popped. A left element passes through
// right-matrix row read, parallel per-column multiply, accumulate. The element
// with the last inner index then emits columns_in_use results in column order,
// one per cycle unless the output stalls, row_last on the final one;
// accumulators and addends clear. Output channel (o_out_valid / i_out_ready) is
// a registered slot; a stall holds the back section in emission while the queue
// keeps taking requests until it fills.
// Config: APB, registers at 0x0 inner_length, 0x4 columns_in_use,
// 0x8 log_modulus; write only while the block is idle.
// Reset (synchronous, active low) empties the queue and clears accumulators
// and addends; the right matrix is undefined until loaded.
`default_nettype none

module modq_matrix_multiply_accumulate
    import mmac_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_INNER   = MAX_INNER_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [2:0]  i_column,
    input  wire logic [9:0]  i_inner_index,
    input  wire logic [15:0] i_value,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [15:0] o_result_value,
    output logic      [2:0]  o_result_column,
    output logic             o_row_last
);

    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int IW    = $clog2(MAX_INNER);
    localparam int LW    = $clog2(MAX_INNER + 1);
    localparam int CNW   = $clog2(MAX_COLUMNS + 1);
    localparam int REQ_W = 2 + CW + IW + VALUE_W + 1;

    logic [10:0]      r_inner_length;
    logic [3:0]       r_columns_in_use;
    logic [4:0]       r_log_modulus;

    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [LW-1:0]    len_eff;
    logic [CNW-1:0]   cols_eff;
    logic [4:0]       lq_eff;
    logic [15:0]      qmask;

    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    logic [REQ_W-1:0] req_in;
    logic [REQ_W-1:0] req_out;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_length   <= INNER_LENGTH_RST;
            r_columns_in_use <= COLUMNS_IN_USE_RST;
            r_log_modulus    <= LOG_MODULUS_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_INNER_LENGTH:   r_inner_length   <= pwdata[10:0];
                REG_COLUMNS_IN_USE: r_columns_in_use <= pwdata[3:0];
                REG_LOG_MODULUS:    r_log_modulus    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_INNER_LENGTH:   prdata = 32'(r_inner_length);
            REG_COLUMNS_IN_USE: prdata = 32'(r_columns_in_use);
            REG_LOG_MODULUS:    prdata = 32'(r_log_modulus);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        if (r_inner_length == '0) begin
            len_eff = LW'(1);
        end else if (32'(r_inner_length) > MAX_INNER) begin
            len_eff = LW'(MAX_INNER);
        end else begin
            len_eff = LW'(r_inner_length);
        end

        if (r_columns_in_use == '0) begin
            cols_eff = CNW'(1);
        end else if (32'(r_columns_in_use) > MAX_COLUMNS) begin
            cols_eff = CNW'(MAX_COLUMNS);
        end else begin
            cols_eff = CNW'(r_columns_in_use);
        end

        if (r_log_modulus == '0) begin
            lq_eff = 5'd1;
        end else if (r_log_modulus > 5'd16) begin
            lq_eff = 5'd16;
        end else begin
            lq_eff = r_log_modulus;
        end
    end

    assign qmask = 16'((17'd1 << lq_eff) - 17'd1);

    mmac_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_INNER  (MAX_INNER)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_column     (i_column),
        .i_inner_index(i_inner_index),
        .i_value      (i_value),
        .i_len        (len_eff),
        .i_full       (q_full),
        .o_push       (push),
        .o_req        (req_in)
    );

    mmac_fifo #(
        .WIDTH(REQ_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (req_in),
        .i_pop  (pop),
        .o_data (req_out),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    mmac_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_INNER  (MAX_INNER)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_out),
        .i_req_valid    (!q_empty),
        .o_pop          (pop),
        .i_cols         (cols_eff),
        .i_qmask        (qmask),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_result_column(o_result_column),
        .o_row_last     (o_row_last)
    );

endmodule

`default_nettype wire

/* tb/mmac_row_checker.sv */
`timescale 1ns / 100ps
// Row checker for the mod-q matrix multiply-accumulate block: follows APB
// register writes and accepted requests, predicts each row's results and
// compares them with the output channel. Depends on mmac_pkg.
module mmac_row_checker
    import mmac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_column,
    input  logic [9:0]  i_inner_index,
    input  logic [15:0] i_value,

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_result_value,
    input  logic [2:0]  i_result_column,
    input  logic        i_row_last,

    output int          o_pending,
    output int          o_mismatches,
    output int          o_results
);

    typedef struct packed {
        logic [15:0] value;
        logic [2:0]  column;
        logic        last;
    } t_row_result;

    t_row_result pending_outputs [$];

    logic [15:0] right_copy [0:MAX_COLUMNS_DEF*MAX_INNER_DEF-1];
    logic [15:0] addends    [0:MAX_COLUMNS_DEF-1];
    logic [15:0] col_sums   [0:MAX_COLUMNS_DEF-1];

    logic [10:0] inner_len_reg;
    logic [3:0]  cols_reg;
    logic [4:0]  log_q_reg;

    int mismatch_count = 0;
    int result_count   = 0;

    function automatic void apply_request(input logic [1:0] op, input logic [2:0] col,
                                          input logic [9:0] idx, input logic [15:0] val);
        int          len;
        int          ncols;
        int          lq;
        logic [15:0] qmask;
        logic [31:0] prod;
        logic [16:0] total;
        t_row_result res;
        len = (inner_len_reg == 0) ? 1 : int'(inner_len_reg);
        if (len > MAX_INNER_DEF) len = MAX_INNER_DEF;
        ncols = (cols_reg == 0) ? 1 : int'(cols_reg);
        if (ncols > MAX_COLUMNS_DEF) ncols = MAX_COLUMNS_DEF;
        lq = (log_q_reg == 0) ? 1 : int'(log_q_reg);
        if (lq > 16) lq = 16;
        qmask = 16'((32'd1 << lq) - 32'd1);
        case (op)
            OP_RIGHT: right_copy[{col, idx}] = val;
            OP_ADDEND: addends[col] = val;
            OP_LEFT: begin
                if (int'(idx) < len) begin
                    for (int c = 0; c < ncols; c++) begin
                        prod = val * right_copy[c*MAX_INNER_DEF + int'(idx)];
                        col_sums[c] = col_sums[c] + prod[15:0];
                    end
                    if (int'(idx) == len - 1) begin
                        for (int c = 0; c < ncols; c++) begin
                            total = {1'b0, col_sums[c]} + {1'b0, addends[c]};
                            res.value = total[15:0] & qmask;
                            res.column = 3'(c);
                            res.last = (c == ncols - 1);
                            pending_outputs.push_back(res);
                        end
                        for (int c = 0; c < MAX_COLUMNS_DEF; c++) begin
                            col_sums[c] = '0;
                            addends[c] = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_row_result want;
        if (!i_rst_n) begin
            inner_len_reg = INNER_LENGTH_RST;
            cols_reg = COLUMNS_IN_USE_RST;
            log_q_reg = LOG_MODULUS_RST;
            for (int c = 0; c < MAX_COLUMNS_DEF; c++) begin
                col_sums[c] = '0;
                addends[c] = '0;
            end
            pending_outputs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_INNER_LENGTH: inner_len_reg = pwdata[10:0];
                    REG_COLUMNS_IN_USE: cols_reg = pwdata[3:0];
                    REG_LOG_MODULUS: log_q_reg = pwdata[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                apply_request(i_operation, i_column, i_inner_index, i_value);
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (pending_outputs.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result value %h column %0d last %b",
                                 $realtime, i_result_value, i_result_column, i_row_last);
                    mismatch_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (want.value !== i_result_value || want.column !== i_result_column ||
                        want.last !== i_row_last) begin
                        if (mismatch_count < 10)
                            $display("%0t: result mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     $realtime, want.value, want.column, want.last,
                                     i_result_value, i_result_column, i_row_last);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= pending_outputs.size();
        o_mismatches <= mismatch_count;
        o_results <= result_count;
    end

endmodule

/* tb/tb_modq_matrix_multiply_accumulate.sv */
`timescale 1ns / 100ps
// Top-level testbench for modq_matrix_multiply_accumulate: clock, reset, APB
// setup and request stimulus; checking is done by mmac_row_checker.
// Depends on mmac_pkg, the block and mmac_row_checker.
module tb_modq_matrix_multiply_accumulate;
    import mmac_pkg::*;

    localparam int RANDOM_ITEMS = 180;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_LIMIT   = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = OP_NONE;
    logic [2:0]  i_column = '0;
    logic [9:0]  i_inner_index = '0;
    logic [15:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_result_value;
    logic [2:0]  o_result_column;
    logic        o_row_last;

    int pending;
    int mismatches;
    int results;

    int send_idle_pct = 6;
    int recv_stall_pct = 79;
    int counted = 0;
    int rows_closed = 0;
    int settings_used = 1;
    int stim_len = MAX_INNER_DEF;
    int idle_cycles = 0;
    bit right_loaded [0:MAX_COLUMNS_DEF-1][0:MAX_INNER_DEF-1];

    always #10 i_clk = ~i_clk;

    modq_matrix_multiply_accumulate DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_column        (i_column),
        .i_inner_index   (i_inner_index),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_value  (o_result_value),
        .o_result_column (o_result_column),
        .o_row_last      (o_row_last)
    );

    mmac_row_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_column        (i_column),
        .i_inner_index   (i_inner_index),
        .i_value         (i_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_result_value  (o_result_value),
        .i_result_column (o_result_column),
        .i_row_last      (o_row_last),
        .o_pending       (pending),
        .o_mismatches    (mismatches),
        .o_results       (results)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[modq_matrix_multiply_accumulate] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [2:0] col,
                                input logic [9:0] idx, input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_column <= col;
        i_inner_index <= idx;
        i_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == OP_RIGHT) right_loaded[col][idx] = 1'b1;
        if (op == OP_RIGHT || op == OP_ADDEND || (op == OP_LEFT && int'(idx) < stim_len))
            counted++;
    endtask

    // left element; any right entry it would read is loaded first
    task automatic send_left(input logic [9:0] idx, input logic [15:0] val);
        for (int c = 0; c < MAX_COLUMNS_DEF; c++) begin
            if (!right_loaded[c][idx])
                send_request(OP_RIGHT, 3'(c), idx, 16'($urandom));
        end
        send_request(OP_LEFT, 3'($urandom_range(7)), idx, val);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [10:0] len, input logic [3:0] cols,
                             input logic [4:0] lq);
        drain();
        write_reg(REG_INNER_LENGTH, 32'(len));
        write_reg(REG_COLUMNS_IN_USE, 32'(cols));
        write_reg(REG_LOG_MODULUS, 32'(lq));
        stim_len = (len == 0) ? 1 : int'(len);
        if (stim_len > MAX_INNER_DEF) stim_len = MAX_INNER_DEF;
        settings_used++;
    endtask

    function automatic logic [9:0] pick_index();
        int span;
        span = (stim_len < 4) ? stim_len : 4;
        if ($urandom_range(7) == 0) return 10'($urandom_range(stim_len - 1));
        if ($urandom_range(1) == 0) return 10'($urandom_range(span - 1));
        return 10'(stim_len - 1 - $urandom_range(span - 1));
    endfunction

    // loads, noise and left elements, closed by the last inner index
    task automatic run_row();
        int extras;
        int pick;
        extras = $urandom_range(5);
        for (int k = 0; k < extras; k++) begin
            pick = $urandom_range(99);
            if (pick < 6)
                send_request(OP_NONE, 3'($urandom), 10'($urandom), 16'($urandom));
            else if (pick < 12 && stim_len < MAX_INNER_DEF)
                send_request(OP_LEFT, 3'($urandom), 10'($urandom_range(1023, stim_len)),
                             16'($urandom));
            else if (pick < 22)
                send_request(OP_RIGHT, 3'($urandom), 10'($urandom), 16'($urandom));
            else if (pick < 40)
                send_request(OP_ADDEND, 3'($urandom), 10'($urandom), 16'($urandom));
            else
                send_left(pick_index(), 16'($urandom));
        end
        send_left(10'(stim_len - 1), 16'($urandom));
        rows_closed++;
    endtask

    initial begin
        logic [15:0] corner_values [0:7];
        int          random_base;
        int          progress;
        int          pick;
        logic [10:0] len;

        corner_values = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
                          16'h7FFF, 16'hAAAA, 16'h5555, 16'h1234};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: two full-length rows, each closed at the top index
        for (int c = 0; c < MAX_COLUMNS_DEF; c++)
            send_request(OP_RIGHT, 3'(c), 10'd1023, corner_values[c]);
        send_request(OP_ADDEND, 3'd0, 10'd0, 16'hFFFF);
        send_request(OP_ADDEND, 3'd7, 10'd1023, 16'h8000);
        send_request(OP_NONE, 3'd7, 10'd1023, 16'hFFFF);
        send_left(10'd1023, 16'hFFFF);
        send_left(10'd1023, 16'h0000);
        rows_closed += 2;

        // zero registers act as one; element past the row is dropped
        configure(11'd0, 4'd0, 5'd0);
        send_left(10'd0, 16'h0003);
        send_request(OP_LEFT, 3'd0, 10'd1, 16'hFFFF);
        rows_closed++;

        configure(11'd2047, 4'd15, 5'd31);
        run_row();
        run_row();
        configure(11'd1, 4'd8, 5'd16);
        run_row();
        run_row();

        random_base = counted;
        while (counted - random_base < RANDOM_ITEMS) begin
            progress = counted - random_base;
            if (progress < RANDOM_ITEMS / 3) begin
                send_idle_pct = 6;
                recv_stall_pct = 79;
            end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 79;
                recv_stall_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if ($urandom_range(3) == 0) begin
                pick = $urandom_range(9);
                if (pick < 5) len = 11'($urandom_range(8, 1));
                else if (pick < 7) len = 11'($urandom_range(2047));
                else if (pick == 7) len = 11'd0;
                else if (pick == 8) len = 11'd1024;
                else len = 11'd2047;
                configure(len, 4'($urandom_range(15)), 5'($urandom_range(31)));
            end
            run_row();
        end

        drain();
        $display("Covered %0d requests in %0d rows over %0d register settings.",
                 counted, rows_closed, settings_used);
        $display("Checked %0d result elements, %0d mismatches.", results, mismatches);
        if (mismatches == 0)
            $display("[modq_matrix_multiply_accumulate] OK");
        else
            $display("[modq_matrix_multiply_accumulate] ERROR");
        $finish;
    end

endmodule
